[rtl/okg_pkg.sv]
// Shared types and constants for the open-addressing key grouper.
package okg_pkg;

	localparam int unsigned OKG_SLOT_COUNT  = 8192;
	localparam int unsigned OKG_MAX_GROUPS  = 4096;
	localparam int unsigned OKG_QUEUE_DEPTH = 2;

	localparam int unsigned OKG_KEY_W   = 32;
	localparam int unsigned OKG_GIDX_W  = 12;
	localparam int unsigned OKG_COUNT_W = 13;
	localparam int unsigned OKG_EPOCH_W = 8;

	localparam logic [31:0]              OKG_HASH_MULT = 32'd2654435761;
	localparam logic [OKG_COUNT_W-1:0]   OKG_COUNT_MAX = 13'h1fff;
	localparam logic [OKG_EPOCH_W-1:0]   OKG_EPOCH_MAX = 8'hff;
	localparam logic [OKG_EPOCH_W-1:0]   OKG_EPOCH_FIRST = 8'h01;

	typedef struct packed {
		logic [OKG_KEY_W-1:0] key;
		logic                 first;
	} okg_in_t;

	typedef struct packed {
		logic [OKG_GIDX_W-1:0]  group_index;
		logic                   is_new;
		logic [OKG_COUNT_W-1:0] member_count;
		logic                   table_error;
	} okg_out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_KEY_CHK
	} okg_state_t;

endpackage

[rtl/okg_fifo.sv]
// Short queue of hashed words between the front end and the probe engine.
module okg_fifo import okg_pkg::*; #(
	parameter int unsigned WIDTH = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output logic [WIDTH-1:0] q_data
);

	localparam int unsigned DEPTH = OKG_QUEUE_DEPTH;
	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/okg_front.sv]
// Input side: takes words, hashes the key to a home slot and queues the job.
module okg_front import okg_pkg::*; #(
	parameter int unsigned SLOT_COUNT = OKG_SLOT_COUNT,
	parameter int unsigned SW         = $clog2(SLOT_COUNT)
) (
	input  logic                      item_valid,
	output logic                      item_ready,
	input  okg_in_t                   item,
	input  logic                      clearing,
	input  logic                      full,
	output logic                      push,
	output logic [SW+OKG_KEY_W:0]     push_data
);

	// Only the low slot bits of key times the multiplier matter, so a narrow
	// product over the low key bits is enough.
	localparam logic [SW-1:0] MULT_LO = OKG_HASH_MULT[SW-1:0];

	logic [2*SW-1:0] prod;
	logic [SW-1:0]   home_slot;

	assign prod      = {{SW{1'b0}}, item.key[SW-1:0]} * {{SW{1'b0}}, MULT_LO};
	assign home_slot = prod[SW-1:0];

	assign item_ready = !full && !clearing;
	assign push       = item_valid && item_ready;
	assign push_data  = {item.first, item.key, home_slot};

endmodule

[rtl/okg_back.sv]
// Probe engine: slot and group memories, linear probing and the result register.
module okg_back import okg_pkg::*; #(
	parameter int unsigned SLOT_COUNT = OKG_SLOT_COUNT,
	parameter int unsigned MAX_GROUPS = OKG_MAX_GROUPS,
	parameter int unsigned SW         = $clog2(SLOT_COUNT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  logic [SW+OKG_KEY_W:0] q_data,
	output logic                  pop,
	output logic                  clearing,
	output logic                  result_valid,
	input  logic                  result_ready,
	output okg_out_t              result
);

	localparam int unsigned GW  = $clog2(MAX_GROUPS);
	localparam int unsigned GTW = $clog2(MAX_GROUPS + 1);
	localparam int unsigned EW  = OKG_EPOCH_W;
	localparam int unsigned SMW = EW + GW;
	localparam int unsigned GMW = OKG_KEY_W + OKG_COUNT_W;

	okg_state_t state_q, state_d;

	logic [SW-1:0]          slot_q;
	logic [OKG_KEY_W-1:0]   key_q;
	logic [SW-1:0]          probe_q;
	logic [SW-1:0]          clr_idx_q;
	logic [EW-1:0]          epoch_q;
	logic                   pend_q;
	logic [GTW-1:0]         group_total_q;
	logic                   out_valid_q;
	okg_out_t               out_q;

	logic [SMW-1:0] slot_mem [SLOT_COUNT];
	logic [SMW-1:0] slot_rd_q;
	logic [GMW-1:0] grp_mem [MAX_GROUPS];
	logic [GMW-1:0] grp_rd_q;

	logic [SW-1:0]        q_slot;
	logic [OKG_KEY_W-1:0] q_key;
	logic                 q_first;

	logic                   slot_re, slot_we, grp_re, grp_we;
	logic [SW-1:0]          slot_raddr, slot_waddr;
	logic [SMW-1:0]         slot_wdata;
	logic [GW-1:0]          grp_raddr, grp_waddr;
	logic [GMW-1:0]         grp_wdata;
	logic                   finish, insert, advance;
	okg_out_t               res;

	logic                   out_free;
	logic                   slot_live;
	logic [GW-1:0]          slot_grp;
	logic [OKG_KEY_W-1:0]   grp_key;
	logic [OKG_COUNT_W-1:0] grp_cnt;
	logic [OKG_COUNT_W-1:0] cnt_next;
	logic                   key_match;
	logic                   groups_full;
	logic [GW-1:0]          new_grp;
	logic [GW+OKG_GIDX_W-1:0] new_gidx_ext;
	logic [GW+OKG_GIDX_W-1:0] hit_gidx_ext;

	assign q_slot  = q_data[SW-1:0];
	assign q_key   = q_data[SW+OKG_KEY_W-1:SW];
	assign q_first = q_data[SW+OKG_KEY_W];

	// A slot counts as occupied only if it was written in the current epoch.
	assign slot_live   = (slot_rd_q[SMW-1:GW] == epoch_q);
	assign slot_grp    = slot_rd_q[GW-1:0];
	assign grp_key     = grp_rd_q[GMW-1:OKG_COUNT_W];
	assign grp_cnt     = grp_rd_q[OKG_COUNT_W-1:0];
	assign cnt_next    = (grp_cnt == OKG_COUNT_MAX) ? grp_cnt : grp_cnt + 1'b1;
	assign key_match   = (grp_key == key_q);
	assign groups_full = (group_total_q == GTW'(MAX_GROUPS));
	assign new_grp     = group_total_q[GW-1:0];
	assign new_gidx_ext = {{OKG_GIDX_W{1'b0}}, new_grp};
	assign hit_gidx_ext = {{OKG_GIDX_W{1'b0}}, slot_grp};
	assign out_free    = !out_valid_q || result_ready;

	assign clearing     = (state_q == ST_CLEAR);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_idx_q) begin
					state_d = pend_q ? ST_SLOT_RD : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					state_d = (q_first && epoch_q == OKG_EPOCH_MAX) ? ST_CLEAR : ST_SLOT_RD;
				end
			end
			ST_SLOT_RD: begin
				state_d = ST_SLOT_CHK;
			end
			ST_SLOT_CHK: begin
				if (slot_live) begin
					state_d = ST_KEY_CHK;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_KEY_CHK: begin
				if (key_match || (&probe_q)) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_SLOT_CHK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		slot_re    = 1'b0;
		slot_we    = 1'b0;
		grp_re     = 1'b0;
		grp_we     = 1'b0;
		slot_raddr = slot_q;
		slot_waddr = slot_q;
		slot_wdata = {epoch_q, new_grp};
		grp_raddr  = slot_grp;
		grp_waddr  = slot_grp;
		grp_wdata  = {key_q, cnt_next};
		finish     = 1'b0;
		insert     = 1'b0;
		advance    = 1'b0;
		res        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_idx_q;
				slot_wdata = '0;
			end
			ST_IDLE: begin
				pop = q_valid;
			end
			ST_SLOT_RD: begin
				slot_re = 1'b1;
			end
			ST_SLOT_CHK: begin
				if (slot_live) begin
					grp_re = 1'b1;
				end else if (out_free) begin
					finish = 1'b1;
					if (groups_full) begin
						res.table_error = 1'b1;
					end else begin
						insert    = 1'b1;
						slot_we   = 1'b1;
						grp_we    = 1'b1;
						grp_waddr = new_grp;
						grp_wdata = {key_q, OKG_COUNT_W'(1)};
						res.group_index  = new_gidx_ext[OKG_GIDX_W-1:0];
						res.is_new       = 1'b1;
						res.member_count = OKG_COUNT_W'(1);
					end
				end
			end
			ST_KEY_CHK: begin
				if (key_match) begin
					if (out_free) begin
						finish = 1'b1;
						grp_we = 1'b1;
						res.group_index  = hit_gidx_ext[OKG_GIDX_W-1:0];
						res.member_count = cnt_next;
					end
				end else if (&probe_q) begin
					// Every slot was probed and none held the key.
					if (out_free) begin
						finish = 1'b1;
						res.table_error = 1'b1;
					end
				end else begin
					advance    = 1'b1;
					slot_re    = 1'b1;
					slot_raddr = slot_q + 1'b1;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (grp_we) begin
			grp_mem[grp_waddr] <= grp_wdata;
		end
		if (grp_re) begin
			grp_rd_q <= grp_mem[grp_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			key_q <= q_key;
		end
		if (finish) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			slot_q        <= '0;
			probe_q       <= '0;
			clr_idx_q     <= '0;
			epoch_q       <= OKG_EPOCH_FIRST;
			pend_q        <= 1'b0;
			group_total_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (&clr_idx_q) begin
					pend_q <= 1'b0;
				end
			end
			if (pop) begin
				slot_q  <= q_slot;
				probe_q <= '0;
				if (q_first) begin
					group_total_q <= '0;
					// Epoch codes have run out: sweep the slots back to epoch zero.
					if (epoch_q == OKG_EPOCH_MAX) begin
						epoch_q   <= OKG_EPOCH_FIRST;
						pend_q    <= 1'b1;
						clr_idx_q <= '0;
					end else begin
						epoch_q <= epoch_q + 1'b1;
					end
				end
			end
			if (advance) begin
				slot_q  <= slot_q + 1'b1;
				probe_q <= probe_q + 1'b1;
			end
			if (insert) begin
				group_total_q <= group_total_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.table_error |->
			out_q.group_index == '0 && !out_q.is_new && out_q.member_count == '0)
		else $error("error result carries nonzero fields");

	a_new_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_new |-> out_q.member_count == OKG_COUNT_W'(1)
			&& !out_q.table_error)
		else $error("new group result without a count of one");

	a_group_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		group_total_q <= GTW'(MAX_GROUPS))
		else $error("group total beyond group storage");

	a_first_resets_groups: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_first |=> group_total_q == '0)
		else $error("first word did not empty the group list");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_ready |=> out_valid_q && $stable(out_q))
		else $error("pending result lost or changed");
`endif

endmodule

[rtl/open_addressing_key_grouper_core.sv]
// Top level of the open-addressing key grouper.
// Assigns each 32-bit key to a group by equality, numbering groups in order of
// first appearance and returning the group number, a new-group flag and the
// running member count (saturating at 8191); a set first flag empties the
// table before the key goes in, and a full table or full group storage gives
// an error word with all other fields zero. The key is hashed on entry and
// queued; the probe engine then walks the slot memory one slot at a time.
// Each probe reads the slot memory and, when the slot is occupied, then the
// group-key memory to compare the stored key. After reset, and on every 255th
// word with first set, the engine sweeps the whole slot memory and takes no
// word meanwhile. A finished result waits in an output register while the
// next key is taken.
module open_addressing_key_grouper_core import okg_pkg::*; #(
	parameter int unsigned SLOT_COUNT = OKG_SLOT_COUNT,
	parameter int unsigned MAX_GROUPS = OKG_MAX_GROUPS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  okg_in_t  item,
	output logic     result_valid,
	input  logic     result_ready,
	output okg_out_t result
);

	localparam int unsigned SW = $clog2(SLOT_COUNT);
	localparam int unsigned QW = SW + OKG_KEY_W + 1;

	logic          push, full, pop, q_valid, clearing;
	logic [QW-1:0] push_data, q_data;

	okg_front #(
		.SLOT_COUNT(SLOT_COUNT),
		.SW        (SW)
	) u_front (
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.clearing  (clearing),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	okg_fifo #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_data   (q_data)
	);

	okg_back #(
		.SLOT_COUNT(SLOT_COUNT),
		.MAX_GROUPS(MAX_GROUPS),
		.SW        (SW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.pop         (pop),
		.clearing    (clearing),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

[test/tb.sv]
// Self-checking testbench for the open-addressing key grouper core.
`timescale 1ns / 1ps

module tb import okg_pkg::*; ();

	localparam logic [31:0] HASH_MUL   = 32'd2654435761;
	localparam int unsigned SLOTS      = OKG_SLOT_COUNT;
	localparam int unsigned GROUPS     = OKG_MAX_GROUPS;
	localparam logic [12:0] COUNT_TOP  = 13'h1fff;
	localparam int          CYCLE_LIMIT = 2000000;
	localparam int          SETTLE_CYCLES = 50;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_ready;
	okg_in_t  item = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	okg_out_t result;

	open_addressing_key_grouper_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial forever #5 clk = ~clk;

	// Shadow of the block's table, used to predict each result word.
	bit          slot_used   [SLOTS];
	logic [11:0] slot_owner  [SLOTS];
	logic [31:0] group_key   [GROUPS];
	logic [12:0] group_size  [GROUPS];
	int unsigned groups_open = 0;

	okg_out_t    pending_groups[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          idle_on = 1'b1;
	int          hold_request = 0;
	int          hold_left = 0;
	int          stall_left = 0;

	function automatic okg_out_t assign_group(input logic [31:0] k, input logic f);
		logic [31:0] h;
		int unsigned slot;
		int unsigned probes;
		bit          found;
		bit          empty;
		logic [11:0] grp;
		logic [12:0] cnt;
		okg_out_t    r;
		found = 1'b0;
		empty = 1'b0;
		grp = '0;
		r = '0;
		if (f) begin
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			groups_open = 0;
		end
		h = k * HASH_MUL;
		slot = h & (SLOTS - 1);
		probes = 0;
		while (probes < SLOTS && !found && !empty) begin
			if (!slot_used[slot]) begin
				empty = 1'b1;
			end else if (group_key[slot_owner[slot]] == k) begin
				found = 1'b1;
				grp = slot_owner[slot];
			end else begin
				slot = (slot + 1) & (SLOTS - 1);
			end
			probes++;
		end
		if (!found && (!empty || groups_open >= GROUPS)) begin
			r.table_error = 1'b1;
			return r;
		end
		if (!found) begin
			grp = groups_open[11:0];
			groups_open++;
			slot_used[slot] = 1'b1;
			slot_owner[slot] = grp;
			group_key[grp] = k;
			group_size[grp] = '0;
			r.is_new = 1'b1;
		end
		cnt = group_size[grp];
		if (cnt < COUNT_TOP) cnt = cnt + 13'd1;
		group_size[grp] = cnt;
		r.group_index = grp;
		r.member_count = cnt;
		return r;
	endfunction

	// Offers one word, predicts its result on acceptance, then maybe idles.
	task automatic send_key(input logic [31:0] k, input logic f);
		okg_in_t w;
		int      gap;
		w.key = k;
		w.first = f;
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		pending_groups.push_back(assign_group(k, f));
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results_done();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_groups.size() != 0) @(posedge clk);
	endtask

	// Receiver: long hold when requested, otherwise random stall bursts.
	always @(posedge clk) begin
		if (hold_request > 0 && hold_left == 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 5) - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		okg_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_groups.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected word: group %0d new %0d count %0d error %0d",
						result.group_index, result.is_new, result.member_count,
						result.table_error);
				mismatches++;
			end else begin
				want = pending_groups.pop_front();
				if (result.group_index !== want.group_index || result.is_new !== want.is_new ||
						result.member_count !== want.member_count ||
						result.table_error !== want.table_error) begin
					if (mismatches < 10) begin
						$display("mismatch: expected group %0d new %0d count %0d error %0d",
							want.group_index, want.is_new, want.member_count,
							want.table_error);
						$display("          got group %0d new %0d count %0d error %0d",
							result.group_index, result.is_new,
							result.member_count, result.table_error);
					end
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic test_directed();
		logic [31:0] cand;
		logic [31:0] h;
		logic [31:0] wrap_key;
		wrap_key = '0;
		// Find a key whose home slot is the last one, to force a wrapping probe.
		for (cand = 0; cand < SLOTS; cand++) begin
			h = cand * HASH_MUL;
			if (h[12:0] == SLOTS - 1) wrap_key = cand;
		end
		idle_on = 1'b1;
		send_key(32'h0000_0000, 1'b1);
		send_key(32'h0000_0000, 1'b0);
		send_key(32'hffff_ffff, 1'b0);
		send_key(32'hffff_ffff, 1'b0);
		// Same low 13 bits as key zero: all share one home slot.
		send_key(32'h0000_2000, 1'b0);
		send_key(32'h8000_0000, 1'b0);
		send_key(32'h8000_0000, 1'b0);
		send_key(32'h0000_2000, 1'b0);
		send_key(wrap_key, 1'b0);
		send_key(wrap_key + 32'h0000_2000, 1'b0);
		send_key(wrap_key + 32'h0000_2000, 1'b0);
		send_key(wrap_key, 1'b0);
		send_key(32'haaaa_aaaa, 1'b0);
		send_key(32'h5555_5555, 1'b0);
		send_key(32'haaaa_aaaa, 1'b0);
		// Clearing with a key that was already present.
		send_key(32'h0000_2000, 1'b1);
		send_key(32'h0000_0000, 1'b0);
		send_key(32'h0000_0000, 1'b1);
		send_key(32'hffff_ffff, 1'b1);
		send_key(32'hffff_ffff, 1'b0);
		send_key(32'h0000_0000, 1'b0);
		wait_results_done();
	endtask

	task automatic test_backpressure();
		int i;
		idle_on = 1'b0;
		hold_request = 400;
		send_key($urandom, 1'b1);
		for (i = 0; i < 15; i++) send_key($urandom_range(0, 3), 1'b0);
		wait_results_done();
		idle_on = 1'b1;
	endtask

	task automatic test_repeated_key();
		logic [31:0] k;
		int          i;
		idle_on = 1'b1;
		k = $urandom;
		send_key(k, 1'b1);
		for (i = 0; i < 40; i++) send_key(k, 1'b0);
		wait_results_done();
	endtask

	task automatic test_shared_home_slot();
		logic [31:0] chain_keys[20];
		logic [31:0] base;
		int          i;
		idle_on = 1'b1;
		base = $urandom;
		// Keys that differ only above the slot bits pile up behind one home slot.
		for (i = 0; i < 20; i++) begin
			chain_keys[i] = base + (32'(i) << 13);
			send_key(chain_keys[i], i == 0);
		end
		for (i = 19; i >= 0; i--) send_key(chain_keys[i], 1'b0);
		wait_results_done();
	endtask

	task automatic test_random_sequences();
		logic [31:0] pool[20];
		logic [31:0] k;
		logic        f;
		int          sent;
		int          n;
		int          i;
		int          pool_n;
		sent = 0;
		while (sent < 320) begin
			idle_on = (sent < 270) ? ($urandom_range(0, 3) != 0) : 1'b0;
			pool_n = $urandom_range(1, 20);
			for (i = 0; i < pool_n; i++) begin
				pool[i] = $urandom;
				if (i > 0 && $urandom_range(0, 2) == 0) pool[i][12:0] = pool[0][12:0];
			end
			n = $urandom_range(5, 40);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) k = $urandom;
				else k = pool[$urandom_range(0, pool_n - 1)];
				f = (i == 0) || ($urandom_range(0, 49) == 0);
				send_key(k, f);
				sent++;
			end
		end
		wait_results_done();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_repeated_key();
		test_shared_home_slot();
		test_random_sequences();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_groups.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
